FILE: hdl/kdar_pkg.sv
// shared types and constants for the key debounce and auto-repeat block
`default_nettype none
package kdar_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0] PRESS_LIMIT = 8'h3F;

    typedef enum logic [1:0] {
        CMD_SCAN   = 2'd0,
        CMD_SINGLE = 2'd1,
        CMD_LONG   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS  = 3'd0,
        REG_FIRST_HOLD      = 3'd1,
        REG_SLOW_INTERVAL   = 3'd2,
        REG_REPEATS_TO_FAST = 3'd3,
        REG_FAST_INTERVAL   = 3'd4
    } reg_idx_t;

    localparam logic [15:0] RST_DEBOUNCE_TICKS  = 16'd20;
    localparam logic [15:0] RST_FIRST_HOLD      = 16'd2500;
    localparam logic [15:0] RST_SLOW_INTERVAL   = 16'd300;
    localparam logic [7:0]  RST_REPEATS_TO_FAST = 8'd10;
    localparam logic [15:0] RST_FAST_INTERVAL   = 16'd50;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] first_hold_delay;
        logic [15:0] slow_repeat_interval;
        logic [7:0]  repeats_before_fast;
        logic [15:0] fast_repeat_interval;
    } cfg_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] port_value;
        logic [7:0] key_code;
    } item_t;

    typedef struct packed {
        logic beep;
        logic hit;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/kdar_cfg.sv
// configuration register file
`default_nettype none
module kdar_cfg
    import kdar_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output      cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DEBOUNCE_TICKS:  cfg_next.debounce_ticks       = wr_data;
                REG_FIRST_HOLD:      cfg_next.first_hold_delay     = wr_data;
                REG_SLOW_INTERVAL:   cfg_next.slow_repeat_interval = wr_data;
                REG_REPEATS_TO_FAST: cfg_next.repeats_before_fast  = wr_data[7:0];
                REG_FAST_INTERVAL:   cfg_next.fast_repeat_interval = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks       <= RST_DEBOUNCE_TICKS;
            cfg_reg.first_hold_delay     <= RST_FIRST_HOLD;
            cfg_reg.slow_repeat_interval <= RST_SLOW_INTERVAL;
            cfg_reg.repeats_before_fast  <= RST_REPEATS_TO_FAST;
            cfg_reg.fast_repeat_interval <= RST_FAST_INTERVAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hdl/kdar_core.sv
// key state registers and the per-beat update logic
`default_nettype none
module kdar_core
    import kdar_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output      result_t result
);

    logic [7:0]  cur_code_reg,  cur_code_next;
    logic [7:0]  prev_code_reg, prev_code_next;
    logic [15:0] stable_reg,    stable_next;
    logic        pressed_reg,   pressed_next;
    logic        taken_reg,     taken_next;
    logic        fast_reg,      fast_next;
    logic [7:0]  repeat_reg,    repeat_next;
    logic [15:0] hold_reg,      hold_next;

    logic        down;
    logic        changed;
    logic        code_match;
    logic [15:0] need;

    assign down       = item.port_value < PRESS_LIMIT;
    assign changed    = prev_code_reg != item.port_value;
    assign code_match = item.key_code == cur_code_reg;
    assign need       = (cfg.debounce_ticks == 16'd0) ? 16'd1 : cfg.debounce_ticks;

    always_comb
    begin
        cur_code_next  = cur_code_reg;
        prev_code_next = prev_code_reg;
        stable_next    = stable_reg;
        pressed_next   = pressed_reg;
        taken_next     = taken_reg;
        fast_next      = fast_reg;
        repeat_next    = repeat_reg;
        hold_next      = hold_reg;
        result         = '0;
        case (item.cmd)
            CMD_SCAN:
            begin
                cur_code_next  = item.port_value;
                prev_code_next = item.port_value;
                if (down && !changed)
                begin
                    if (stable_reg != 16'hFFFF)
                        stable_next = stable_reg + 16'd1;
                end
                else
                begin
                    // release or new code: restart debounce
                    stable_next  = '0;
                    pressed_next = 1'b0;
                    taken_next   = 1'b0;
                    fast_next    = 1'b0;
                end
                if (changed)
                    repeat_next = '0;
                if (stable_next == need && !pressed_next)
                begin
                    pressed_next = 1'b1;
                    result.beep  = 1'b1;
                end
                if (hold_reg != 16'd0)
                    hold_next = hold_reg - 16'd1;
            end
            CMD_SINGLE:
            begin
                if (code_match && pressed_reg && !taken_reg)
                begin
                    taken_next = 1'b1;
                    hold_next  = cfg.first_hold_delay;
                    result.hit = 1'b1;
                end
            end
            CMD_LONG:
            begin
                if (code_match && pressed_reg && hold_reg == 16'd0)
                begin
                    result.hit = 1'b1;
                    if (!fast_reg)
                    begin
                        hold_next   = cfg.slow_repeat_interval;
                        repeat_next = repeat_reg + 8'd1;
                        if (repeat_reg == cfg.repeats_before_fast)
                            fast_next = 1'b1;
                    end
                    else
                    begin
                        hold_next = cfg.fast_repeat_interval;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_code_reg  <= '0;
            prev_code_reg <= '0;
            stable_reg    <= '0;
            pressed_reg   <= 1'b0;
            taken_reg     <= 1'b0;
            fast_reg      <= 1'b0;
            repeat_reg    <= '0;
            hold_reg      <= '0;
        end
        else if (step)
        begin
            cur_code_reg  <= cur_code_next;
            prev_code_reg <= prev_code_next;
            stable_reg    <= stable_next;
            pressed_reg   <= pressed_next;
            taken_reg     <= taken_next;
            fast_reg      <= fast_next;
            repeat_reg    <= repeat_next;
            hold_reg      <= hold_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/key_debounce_auto_repeat.sv
// top level of the keypad debounce and auto-repeat qualifier
//
// usage
//   s_* stream carries one item per beat: s_tuser holds the command (scan
//   tick, single-press query or long-press query), s_tdata the port sample
//   and the key code asked about
//   m_* stream returns exactly one result beat per input beat: beep on a
//   scan tick that confirms a new press, hit on a query that reports an event
//   cfg_* channel writes the five timing registers; it is always ready and
//   is meant to be used only while no beat is in flight
// timing
//   a beat is captured in the input register, evaluated against the key
//   state by combinational logic and lands in the output register, which
//   presents the result
//   throughput is one beat per cycle while m_tready stays high; the key
//   state is updated as each beat moves between the two registers
// reset and stalls
//   reset clears the key state and both stages and loads the register
//   defaults; while m_tready is low a full output register holds, the input
//   register still fills once, and s_tready then drops until the result leaves
`default_nettype none
module key_debounce_auto_repeat
    import kdar_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [15:0]           s_tdata,    // [7:0] port_value, [15:8] key_code
    input  wire logic [1:0]            s_tuser,    // [1:0] cmd
    // result stream
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [7:0]            m_tdata,    // [0] beep, [1] hit, [7:2] zero
    // configuration writes
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;

    kdar_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the held beat moves on when the output register is empty or emptying
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register: payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.cmd        <= cmd_t'(s_tuser);
            in_item_reg.port_value <= s_tdata[7:0];
            in_item_reg.key_code   <= s_tdata[15:8];
        end
    end

    kdar_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.hit, out_reg.beep};

endmodule
`default_nettype wire

FILE: test/key_debounce_auto_repeat_checker.sv
// checker for the keypad qualifier: key-state prediction and result comparison
module key_debounce_auto_repeat_checker
    import kdar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [7:0] port_value, [15:8] key_code
    input  logic [1:0]            s_tuser,    // [1:0] cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,    // [0] beep, [1] hit, [7:2] zero
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t        timing;
    logic [7:0]  cur_code;
    logic [7:0]  prev_code;
    logic [15:0] stable_cnt;
    logic        pressed;
    logic        press_taken;
    logic        fast_mode;
    logic [7:0]  repeat_cnt;
    logic [15:0] hold_timer;

    result_t     pending_results[$];
    result_t     want_r;
    result_t     got_r;
    int          result_no = 0;

    initial fail_count = 0;

    function automatic void store_timing(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DEBOUNCE_TICKS:  timing.debounce_ticks       = val;
            REG_FIRST_HOLD:      timing.first_hold_delay     = val;
            REG_SLOW_INTERVAL:   timing.slow_repeat_interval = val;
            REG_REPEATS_TO_FAST: timing.repeats_before_fast  = val[7:0];
            REG_FAST_INTERVAL:   timing.fast_repeat_interval = val;
            default: ;
        endcase
    endfunction

    // advances the key state by one beat and returns the beep/hit it causes
    function automatic result_t qualify_beat(cmd_t cmd, logic [7:0] port, logic [7:0] key);
        result_t     r;
        logic [15:0] need;
        r = '0;
        case (cmd)
            CMD_SCAN:
            begin
                need = (timing.debounce_ticks == 16'd0) ? 16'd1 : timing.debounce_ticks;
                cur_code = port;
                if (port < PRESS_LIMIT)
                begin
                    if (stable_cnt != 16'hFFFF)
                        stable_cnt = stable_cnt + 16'd1;
                end
                else
                begin
                    stable_cnt  = '0;
                    pressed     = 1'b0;
                    press_taken = 1'b0;
                    fast_mode   = 1'b0;
                end
                if (prev_code != port)
                begin
                    stable_cnt  = '0;
                    pressed     = 1'b0;
                    repeat_cnt  = '0;
                    press_taken = 1'b0;
                    fast_mode   = 1'b0;
                end
                prev_code = port;
                if (stable_cnt == need && !pressed)
                begin
                    pressed = 1'b1;
                    r.beep  = 1'b1;
                end
                if (hold_timer != 16'd0)
                    hold_timer = hold_timer - 16'd1;
            end
            CMD_SINGLE:
            begin
                if (key == cur_code && pressed && !press_taken)
                begin
                    press_taken = 1'b1;
                    hold_timer  = timing.first_hold_delay;
                    r.hit       = 1'b1;
                end
            end
            CMD_LONG:
            begin
                if (key == cur_code && pressed && hold_timer == 16'd0)
                begin
                    r.hit = 1'b1;
                    if (!fast_mode)
                    begin
                        hold_timer = timing.slow_repeat_interval;
                        if (repeat_cnt == timing.repeats_before_fast)
                            fast_mode = 1'b1;
                        repeat_cnt = repeat_cnt + 8'd1;
                    end
                    else
                        hold_timer = timing.fast_repeat_interval;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_fail(string what, logic [7:0] want, logic [7:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: result beat %0d: %s, expected %0h got %0h",
                     $time, result_no, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing.debounce_ticks       = RST_DEBOUNCE_TICKS;
            timing.first_hold_delay     = RST_FIRST_HOLD;
            timing.slow_repeat_interval = RST_SLOW_INTERVAL;
            timing.repeats_before_fast  = RST_REPEATS_TO_FAST;
            timing.fast_repeat_interval = RST_FAST_INTERVAL;
            cur_code    = '0;
            prev_code   = '0;
            stable_cnt  = '0;
            pressed     = 1'b0;
            press_taken = 1'b0;
            fast_mode   = 1'b0;
            repeat_cnt  = '0;
            hold_timer  = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                store_timing(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
            begin
                result_no++;
                got_r.beep = m_tdata[0];
                got_r.hit  = m_tdata[1];
                if (pending_results.size() == 0)
                    note_fail("result with no beat waiting", 8'h00, m_tdata);
                else
                begin
                    want_r = pending_results.pop_front();
                    if (got_r.beep !== want_r.beep)
                        note_fail("beep", 8'(want_r.beep), 8'(got_r.beep));
                    if (got_r.hit !== want_r.hit)
                        note_fail("hit", 8'(want_r.hit), 8'(got_r.hit));
                    if (m_tdata[7:2] !== 6'd0)
                        note_fail("padding", 8'h00, 8'(m_tdata[7:2]));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(qualify_beat(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]));
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: test/key_debounce_auto_repeat_tb.sv
// testbench top for the keypad qualifier: stimulus, stall patterns and verdict
module key_debounce_auto_repeat_tb;
    import kdar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // generous ceiling: the whole run is some thousand beats
    localparam int CYCLE_LIMIT = 200_000;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_MOST,
        PACE_HALF,
        PACE_SPARSE
    } rx_pace_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;    // [7:0] port_value, [15:8] key_code
    logic [1:0]            s_tuser   = '0;    // [1:0] cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;           // [0] beep, [1] hit, [7:2] zero
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int       fail_count;
    int       outstanding;
    int       cycle_count = 0;
    int       beats_sent  = 0;
    int       burst_left  = 0;
    int       gap_max     = 6;
    cfg_t     cfg_now;
    rx_pace_t rx_pace     = PACE_FULL;
    int       pace_left   = 0;

    key_debounce_auto_repeat u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_debounce_auto_repeat_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("key_debounce_auto_repeat test failed");
            $finish;
        end
    end

    // receiver back-pressure: the pace switches now and then between always ready,
    // mostly ready, half and sparse, so stalls land on every part of the pipeline
    always @(posedge clk)
    begin
        if (pace_left == 0)
        begin
            rx_pace   <= rx_pace_t'($urandom_range(PACE_FULL, PACE_SPARSE));
            pace_left <= $urandom_range(16, 96);
        end
        else
            pace_left <= pace_left - 1;
        case (rx_pace)
            PACE_FULL:   m_tready <= 1'b1;
            PACE_MOST:   m_tready <= ($urandom_range(0, 3) != 0);
            PACE_HALF:   m_tready <= 1'($urandom_range(0, 1));
            PACE_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= 1'b1;
        endcase
    end

    // one input beat; bursts of random length with random gaps between them,
    // and tvalid stays high straight through a burst
    task automatic send_beat(cmd_t cmd, logic [7:0] port, logic [7:0] key);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {key, port};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    // mostly asks about the held key, now and then about some other code
    task automatic send_query(logic [7:0] code);
        logic [7:0] key;
        key = ($urandom_range(0, 7) == 0) ? 8'($urandom) : code;
        if ($urandom_range(0, 2) == 0)
            send_beat(CMD_SINGLE, 8'($urandom), key);
        else
            send_beat(CMD_LONG, 8'($urandom), key);
    endtask

    // sender holds off until every result has come back
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // keeps cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // only written with the pipeline empty
    task automatic load_settings(logic [15:0] debounce, logic [15:0] first_hold,
                                 logic [15:0] slow, logic [7:0] to_fast,
                                 logic [15:0] fast, logic poke_unused);
        settle();
        write_reg(REG_DEBOUNCE_TICKS, debounce);
        write_reg(REG_FIRST_HOLD, first_hold);
        write_reg(REG_SLOW_INTERVAL, slow);
        // upper byte is junk and must be dropped
        write_reg(REG_REPEATS_TO_FAST, {8'($urandom), to_fast});
        write_reg(REG_FAST_INTERVAL, fast);
        if (poke_unused)
        begin
            // indexes past the register list must change nothing
            for (int i = int'(REG_FAST_INTERVAL) + 1; i < (1 << CFG_IDX_W); i++)
                write_reg(CFG_IDX_W'(i), 16'($urandom));
        end
        cfg_valid <= 1'b0;
        cfg_now.debounce_ticks       = debounce;
        cfg_now.first_hold_delay     = first_hold;
        cfg_now.slow_repeat_interval = slow;
        cfg_now.repeats_before_fast  = to_fast;
        cfg_now.fast_repeat_interval = fast;
    endtask

    // one key session: a code held for at least the debounce count with queries
    // mixed in, occasional glitch samples and stray beats, then a release
    task automatic key_session();
        logic [7:0] code;
        int         need;
        int         hold_n;
        need = (cfg_now.debounce_ticks == 16'd0) ? 1 : int'(cfg_now.debounce_ticks);
        if ($urandom_range(0, 7) == 0)
            code = 8'($urandom_range(PRESS_LIMIT, 8'hFF));
        else
            code = 8'($urandom_range(0, PRESS_LIMIT - 8'd1));
        hold_n = need + $urandom_range(0, 40);
        for (int i = 0; i < hold_n; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_beat(CMD_SCAN, 8'($urandom), 8'($urandom));
            else
                send_beat(CMD_SCAN, code, 8'($urandom));
            if ($urandom_range(0, 1) == 1)
                send_query(code);
            if ($urandom_range(0, 24) == 0)
                send_beat(cmd_t'($urandom_range(CMD_SCAN, CMD_NONE)), 8'($urandom), 8'($urandom));
        end
        repeat ($urandom_range(1, 3))
        begin
            send_beat(CMD_SCAN, 8'($urandom_range(PRESS_LIMIT, 8'hFF)), 8'($urandom));
            if ($urandom_range(0, 1) == 1)
                send_query(code);
        end
        if ($urandom_range(0, 15) == 0)
            settle();
    endtask

    task automatic run_sessions(int n_beats);
        int target;
        target = beats_sent + n_beats;
        while (beats_sent < target)
            key_session();
    endtask

    initial
    begin
        logic [7:0] code;
        cfg_now.debounce_ticks       = RST_DEBOUNCE_TICKS;
        cfg_now.first_hold_delay     = RST_FIRST_HOLD;
        cfg_now.slow_repeat_interval = RST_SLOW_INTERVAL;
        cfg_now.repeats_before_fast  = RST_REPEATS_TO_FAST;
        cfg_now.fast_repeat_interval = RST_FAST_INTERVAL;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: unused command, queries with nothing pressed,
        // release exactly at the press limit and well above it
        send_beat(CMD_NONE, 8'hFF, 8'hFF);
        send_beat(CMD_SINGLE, 8'h00, 8'h00);
        send_beat(CMD_LONG, 8'h00, 8'h00);
        send_beat(CMD_SCAN, PRESS_LIMIT, 8'hFF);
        send_beat(CMD_SCAN, 8'hFF, 8'h00);
        send_beat(CMD_SCAN, 8'h00, 8'h00);

        // all registers at zero: zero debounce behaves as one tick, repeats
        // go fast straight away
        load_settings(16'd0, 16'd0, 16'd0, 8'd0, 16'd0, 1'b0);
        send_beat(CMD_SCAN, PRESS_LIMIT - 8'd1, 8'h00);
        send_beat(CMD_SCAN, PRESS_LIMIT - 8'd1, 8'h00);
        send_beat(CMD_SINGLE, 8'h00, PRESS_LIMIT - 8'd1);
        send_beat(CMD_SINGLE, 8'h00, PRESS_LIMIT - 8'd1);
        send_beat(CMD_SINGLE, 8'h00, PRESS_LIMIT - 8'd2);
        send_beat(CMD_LONG, 8'h00, PRESS_LIMIT - 8'd1);
        send_beat(CMD_LONG, 8'hFF, PRESS_LIMIT - 8'd1);
        send_beat(CMD_SCAN, PRESS_LIMIT - 8'd1, 8'h00);
        send_beat(CMD_NONE, PRESS_LIMIT - 8'd1, PRESS_LIMIT - 8'd1);
        // code change to a released value, then a query that must miss
        send_beat(CMD_SCAN, PRESS_LIMIT + 8'd1, 8'h00);
        send_beat(CMD_SCAN, PRESS_LIMIT + 8'd1, 8'h00);
        send_beat(CMD_LONG, 8'h00, PRESS_LIMIT + 8'd1);
        send_beat(CMD_SCAN, PRESS_LIMIT - 8'd2, 8'hFF);
        send_beat(CMD_SCAN, PRESS_LIMIT - 8'd2, 8'hFF);
        // change between two pressed codes
        send_beat(CMD_SCAN, PRESS_LIMIT - 8'd3, 8'h00);
        send_beat(CMD_LONG, 8'h00, PRESS_LIMIT - 8'd2);

        // random phases over a spread of small timings, then the reset defaults
        load_settings(16'd3, 16'd4, 16'd2, 8'd2, 16'd1, 1'b1);
        run_sessions(120);
        load_settings(16'd1, 16'd0, 16'd0, 8'd3, 16'd0, 1'b0);
        run_sessions(120);
        repeat (3)
        begin
            load_settings(16'($urandom_range(0, 5)), 16'($urandom_range(0, 8)),
                          16'($urandom_range(0, 6)), 8'($urandom_range(0, 5)),
                          16'($urandom_range(0, 3)), 1'b0);
            run_sessions(50);
        end
        load_settings(RST_DEBOUNCE_TICKS, RST_FIRST_HOLD, RST_SLOW_INTERVAL,
                      RST_REPEATS_TO_FAST, RST_FAST_INTERVAL, 1'b0);
        run_sessions(60);

        // repeat count all the way round: 255 slow repeats before fast mode,
        // the count wraps on the step that switches to fast
        load_settings(16'd1, 16'd0, 16'd0, 8'd255, 16'd0, 1'b0);
        code = 8'($urandom_range(0, PRESS_LIMIT - 8'd1));
        send_beat(CMD_SCAN, 8'hFF, 8'h00);
        send_beat(CMD_SCAN, code, 8'h00);
        send_beat(CMD_SCAN, code, 8'h00);
        for (int i = 0; i < 300; i++)
        begin
            send_beat(CMD_LONG, 8'($urandom), code);
            if ($urandom_range(0, 15) == 0)
                send_beat(CMD_SCAN, code, 8'($urandom));
        end
        send_beat(CMD_SCAN, 8'hFF, 8'h00);

        // all timings but the repeat count at maximum: the press cannot confirm
        // within this hold, so every query misses
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 16'hFFFF, 1'b0);
        gap_max = 1;
        code = 8'($urandom_range(0, PRESS_LIMIT - 8'd1));
        for (int i = 0; i < 120; i++)
        begin
            send_beat(CMD_SCAN, code, 8'($urandom));
            if (i % 16 == 15)
                send_query(code);
        end
        send_beat(CMD_SINGLE, 8'h00, code);
        send_beat(CMD_LONG, 8'h00, code);
        send_beat(CMD_SCAN, 8'hFF, 8'h00);
        gap_max = 6;

        // drain, then allow the two-stage pipeline to go quiet
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("key_debounce_auto_repeat test passed");
        else
            $display("key_debounce_auto_repeat test failed");
        $finish;
    end

endmodule

FILE: key_debounce_auto_repeat.f
hdl/kdar_pkg.sv
hdl/kdar_cfg.sv
hdl/kdar_core.sv
hdl/key_debounce_auto_repeat.sv
test/key_debounce_auto_repeat_checker.sv
test/key_debounce_auto_repeat_tb.sv
